FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ica_pkg.sv
// shared types, opcodes and constants of the integer calculator alu
// no dependencies
package ica_pkg;

  localparam int WIDTH = 32;
  localparam int MUL_W = 32;
  localparam int ADD_W = WIDTH + 1;
  localparam int VAL_W = 64;
  localparam int ACC_W = 3 * MUL_W + 1;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               div_by_zero;
    logic               overflow;
  } out_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic             sub;
    logic [ADD_W-1:0] x;
    logic [ADD_W-1:0] y;
    logic [MUL_W-1:0] mx;
    logic [MUL_W-1:0] my;
  } unit_req_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  function automatic logic [VAL_W-1:0] sext_w(input logic [WIDTH-1:0] v);
    return {{(VAL_W-WIDTH){v[WIDTH-1]}}, v};
  endfunction

endpackage

FILE: hw/rtl/integer_calculator_alu_core.sv
// each operation steps through sequencer states: add/sub through S_ADDSUB, multiply through
// S_MUL and S_MULW, divide through S_DIV once per quotient bit, then S_DIVFIX for a negative
// quotient; zero divisor, unused op or exponent <= 0 go straight to S_DONE; power squares on
// the shared unit per exponent bit and multiplies per set bit, ending early on saturation
// a new request is taken only once the previous result has entered the output register
// reset (rst, synchronous, active high) idles the sequencer and empties the output register
module integer_calculator_alu_core import ica_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  in_t  req_data,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_data
);

  seq_ctl_t  ctl;
  seq_stat_t stat;
  out_t      seq_result;
  logic      load;

  // a request is taken only while the sequencer sits idle, even with a result waiting,
  // and never while reset is held
  assign req_ready = stat.idle && !rst;
  // move a finished result out when the output register is empty or being drained
  assign load      = stat.done && (!res_valid || res_ready);
  assign ctl.start = req_valid && req_ready;
  assign ctl.ack   = load;

  ica_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req_data),
    .stat   (stat),
    .result (seq_result)
  );

  // output register holds the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_data <= seq_result;
  end

endmodule

FILE: hw/rtl/ica_unit.sv
// shared arithmetic unit: add/subtract with carry out, registered multiplier
// depends on ica_pkg
module ica_unit import ica_pkg::*; (
  input  logic                 clk,
  input  unit_req_t            req,
  output logic [ADD_W:0]       sum,
  output logic [2*MUL_W-1:0]   prod
);

  logic [ADD_W-1:0] y_inv;

  assign y_inv = req.sub ? ~req.y : req.y;
  // carry out is the no-borrow flag for subtraction
  assign sum = {1'b0, req.x} + {1'b0, y_inv} + (ADD_W+1)'(req.sub);

  always_ff @(posedge clk) begin
    prod <= req.mx * req.my;
  end

endmodule

FILE: hw/rtl/ica_seq.sv
// sequencer: steps add, multiply, divide and power through the shared unit
// depends on ica_pkg and ica_unit
module ica_seq import ica_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  seq_ctl_t  ctl,
  input  in_t       req,
  output seq_stat_t stat,
  output out_t      result
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADDSUB, S_MUL, S_MULW, S_DIV, S_DIVFIX,
    S_PW_SQ, S_PW_SQW, S_PW_MLO, S_PW_MHI, S_PW_ACC, S_PW_CHK, S_DONE
  } state_t;

  state_t               state;
  logic                 sub_r;
  logic [WIDTH-1:0]     a_r;
  logic [WIDTH-1:0]     b_r;
  logic [WIDTH-1:0]     mag_a;
  logic [WIDTH-1:0]     mag_b;
  logic                 neg_q;
  logic                 neg_pw;
  logic [WIDTH-1:0]     q;
  logic [WIDTH-1:0]     rem;
  logic [CNT_W-1:0]     cnt;
  logic [VAL_W-1:0]     r;
  logic [2*MUL_W-1:0]   plo;
  logic [ACC_W-1:0]     acc;
  logic [VAL_W-1:0]     value;
  logic                 dz;
  logic                 ovf;

  logic [WIDTH-1:0]     a_in;
  logic [WIDTH-1:0]     b_in;
  logic [WIDTH-1:0]     mag_a_in;
  logic [WIDTH-1:0]     mag_b_in;
  logic [ADD_W-1:0]     shifted;
  logic [WIDTH-1:0]     q_next;
  logic [VAL_W-1:0]     limit;
  unit_req_t            ureq;
  logic [ADD_W:0]       sum;
  logic [2*MUL_W-1:0]   prod;

  function automatic logic [VAL_W-1:0] apply_sign(input logic neg, input logic [VAL_W-1:0] m);
    return neg ? (~m + 1'b1) : m;
  endfunction

  assign a_in     = req.operand_a[WIDTH-1:0];
  assign b_in     = req.operand_b[WIDTH-1:0];
  assign mag_a_in = a_in[WIDTH-1] ? (~a_in + 1'b1) : a_in;
  assign mag_b_in = b_in[WIDTH-1] ? (~b_in + 1'b1) : b_in;
  assign shifted  = {rem, q[WIDTH-1]};
  assign q_next   = {q[WIDTH-2:0], sum[ADD_W]};
  // saturation bound, also the saturated value
  assign limit    = neg_pw ? VAL_MIN : VAL_MAX;

  always_comb begin
    ureq     = '0;
    ureq.sub = 1'b1;
    case (state)
      S_ADDSUB: begin
        ureq.sub = sub_r;
        ureq.x   = {1'b0, a_r};
        ureq.y   = {1'b0, b_r};
      end
      S_DIV: begin
        ureq.x = shifted;
        ureq.y = {1'b0, mag_b};
      end
      S_DIVFIX: begin
        ureq.y = {1'b0, q};
      end
      S_MUL: begin
        ureq.mx = MUL_W'(a_r);
        ureq.my = MUL_W'(b_r);
      end
      S_PW_SQ: begin
        ureq.mx = r[MUL_W-1:0];
        ureq.my = r[MUL_W-1:0];
      end
      S_PW_MLO: begin
        ureq.mx = r[MUL_W-1:0];
        ureq.my = MUL_W'(mag_a);
      end
      S_PW_MHI: begin
        ureq.mx = r[2*MUL_W-1:MUL_W];
        ureq.my = MUL_W'(mag_a);
      end
      default: ;
    endcase
  end

  ica_unit u_unit (
    .clk  (clk),
    .req  (ureq),
    .sum  (sum),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            a_r    <= a_in;
            b_r    <= b_in;
            mag_a  <= mag_a_in;
            mag_b  <= mag_b_in;
            neg_q  <= a_in[WIDTH-1] ^ b_in[WIDTH-1];
            neg_pw <= a_in[WIDTH-1] & b_in[0];
            sub_r  <= (req.op == OP_SUB);
            value  <= '0;
            dz     <= 1'b0;
            ovf    <= 1'b0;
            case (req.op)
              OP_ADD, OP_SUB: state <= S_ADDSUB;
              OP_MUL: state <= S_MUL;
              OP_DIV: begin
                if (b_in == '0) begin
                  dz    <= 1'b1;
                  state <= S_DONE;
                end else begin
                  q     <= mag_a_in;
                  rem   <= '0;
                  cnt   <= CNT_W'(WIDTH - 1);
                  state <= S_DIV;
                end
              end
              OP_POW: begin
                if (b_in[WIDTH-1] || b_in == '0) begin
                  value <= VAL_W'(1);
                  state <= S_DONE;
                end else begin
                  r     <= VAL_W'(1);
                  cnt   <= CNT_W'(WIDTH - 2);
                  state <= S_PW_SQ;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ADDSUB: begin
          value <= sext_w(sum[WIDTH-1:0]);
          state <= S_DONE;
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          value <= sext_w(prod[WIDTH-1:0]);
          state <= S_DONE;
        end
        S_DIV: begin
          q   <= q_next;
          rem <= sum[ADD_W] ? sum[WIDTH-1:0] : shifted[WIDTH-1:0];
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            value <= sext_w(q_next);
            state <= neg_q ? S_DIVFIX : S_DONE;
          end
        end
        S_DIVFIX: begin
          value <= sext_w(sum[WIDTH-1:0]);
          state <= S_DONE;
        end
        S_PW_SQ: begin
          // a square of anything at or above 2^32 is past any limit
          if (r[VAL_W-1:MUL_W] != '0) begin
            ovf   <= 1'b1;
            value <= limit;
            state <= S_DONE;
          end else begin
            state <= S_PW_SQW;
          end
        end
        S_PW_SQW: begin
          if (prod > limit) begin
            ovf   <= 1'b1;
            value <= limit;
            state <= S_DONE;
          end else begin
            r <= prod;
            if (b_r[cnt]) begin
              state <= S_PW_MLO;
            end else if (cnt == '0) begin
              value <= apply_sign(neg_pw, prod);
              state <= S_DONE;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_PW_SQ;
            end
          end
        end
        S_PW_MLO: state <= S_PW_MHI;
        S_PW_MHI: begin
          plo   <= prod;
          state <= S_PW_ACC;
        end
        S_PW_ACC: begin
          acc   <= ACC_W'({prod, {MUL_W{1'b0}}}) + ACC_W'(plo);
          state <= S_PW_CHK;
        end
        S_PW_CHK: begin
          if (acc > ACC_W'(limit)) begin
            ovf   <= 1'b1;
            value <= limit;
            state <= S_DONE;
          end else begin
            r <= acc[VAL_W-1:0];
            if (cnt == '0) begin
              value <= apply_sign(neg_pw, acc[VAL_W-1:0]);
              state <= S_DONE;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_PW_SQ;
            end
          end
        end
        S_DONE: begin
          if (ctl.ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle          = (state == S_IDLE);
  assign stat.done          = (state == S_DONE);
  assign result.value       = value;
  assign result.div_by_zero = dz;
  assign result.overflow    = ovf;

endmodule

FILE: hw/rtl/ica_checker.sv
// port-level checks of the integer calculator alu, bound to the top level
// depends on ica_pkg and assert_macros.svh
`include "assert_macros.svh"

module ica_checker import ica_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input out_t res_data
);

  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data), "stalled result changed")
  `CHK_ASSERT(a_busy_after_req, clk, rst, req_valid && req_ready |=> !req_ready, "ready right after a request")
  `CHK_IMPLY(a_flags_excl, clk, rst, res_valid, !(res_data.div_by_zero && res_data.overflow), "both flags set")
  `CHK_IMPLY(a_dz_zero, clk, rst, res_valid && res_data.div_by_zero, res_data.value == '0, "divide by zero with nonzero value")
  `CHK_IMPLY(a_ovf_sat, clk, rst, res_valid && res_data.overflow, res_data.value == VAL_MAX || res_data.value == VAL_MIN, "overflow without saturated value")

endmodule

bind integer_calculator_alu_core ica_checker u_ica_checker (.*);

FILE: tb/integer_calculator_alu_core_tb.sv
// self-checking testbench for integer_calculator_alu_core: directed corners, random traffic
// and output back-pressure, results checked against an in-bench arithmetic predictor
// depends on ica_pkg (request/result structs, opcodes, saturation limits)
`timescale 1ns / 1ps

module integer_calculator_alu_core_tb;
  import ica_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 8;
  // cycles with pending work but no handshake on either side before giving up;
  // covers the long output hold plus a worst-case power loop several times over
  localparam int STALL_LIMIT = 4000;
  // wait past the worst-case power loop at the end
  localparam int DRAIN_CYCLES = 6 * WIDTH + 60;
  localparam int LONG_HOLD = 300;

  // operation codes the block does not implement
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  in_t  req_data;
  logic res_valid;
  logic res_ready;
  out_t res_data;

  integer_calculator_alu_core uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  // results predicted for accepted requests, oldest first
  out_t pending_results[$];

  int errors = 0;
  int results_checked = 0;
  int dz_seen = 0;
  int sat_seen = 0;
  int op_count[8];

  // sender idling: bursts of back-to-back requests, random gaps between them
  int burst_left = 0;
  int gap_max = 8;

  // receiver stall pattern; the long hold is counted down by the receiver itself
  int rx_stall_cap = 60;
  int hold_request = 0;
  int long_hold = 0;
  int rx_phase_left = 0;
  int rx_stall_pct = 0;

  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ------------------------------------------------------------------
  // predictor: wrap add/sub/mul/div to WIDTH bits, exact power saturated
  // to the signed 64-bit range
  // ------------------------------------------------------------------
  function automatic out_t predict_result(in_t req);
    logic signed [WIDTH-1:0] aw, bw, wrapped;
    longint sa, sb, quot;
    longint unsigned base, bound, acc;
    bit neg, saturated;
    out_t r;
    aw = req.operand_a[WIDTH-1:0];
    bw = req.operand_b[WIDTH-1:0];
    sa = aw;
    sb = bw;
    r = '0;
    case (req.op)
      OP_ADD: begin
        wrapped = aw + bw;
        r.value = wrapped;
      end
      OP_SUB: begin
        wrapped = aw - bw;
        r.value = wrapped;
      end
      OP_MUL: begin
        wrapped = aw * bw;
        r.value = wrapped;
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // 64-bit division truncates toward zero; min / -1 wraps when cut back
          quot = sa / sb;
          wrapped = quot[WIDTH-1:0];
          r.value = wrapped;
        end
      end
      OP_POW: begin
        if (sb <= 0) begin
          r.value = 64'sd1;
        end else begin
          base = (sa < 0) ? longint'(-sa) : longint'(sa);
          neg = (sa < 0) && sb[0];
          if (base == 0) begin
            r.value = 64'sd0;
          end else if (base == 1) begin
            r.value = neg ? -64'sd1 : 64'sd1;
          end else begin
            // magnitude limit differs by one between the two signs
            bound = neg ? VAL_MIN : VAL_MAX;
            acc = 1;
            saturated = 1'b0;
            for (int i = 0; i < 64 && i < sb && !saturated; i++) begin
              if (acc > bound / base) begin
                saturated = 1'b1;
                r.overflow = 1'b1;
                r.value = neg ? VAL_MIN : VAL_MAX;
              end else begin
                acc = acc * base;
              end
            end
            if (!saturated) r.value = neg ? -acc : acc;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic in_t make_request(logic [2:0] op, logic signed [31:0] a,
                                       logic signed [31:0] b);
    in_t r;
    r.op = op;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  // operand mix: corners, small magnitudes of either sign, full 32-bit noise
  function automatic logic signed [31:0] random_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = MAX32;
          4: v = MIN32;
          5: v = MAX32 - 1;
          default: v = MIN32 + 1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic in_t random_request();
    in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.operand_a = random_operand();
    r.operand_b = random_operand();
    if (pick < 19) r.op = OP_ADD;
    else if (pick < 38) r.op = OP_SUB;
    else if (pick < 57) r.op = OP_MUL;
    else if (pick < 77) r.op = OP_DIV;
    else if (pick < 95) begin
      r.op = OP_POW;
      // mostly small bases and exponents so both exact and saturated results show up
      if ($urandom_range(0, 3) != 0) begin
        r.operand_a = $urandom_range(0, 24);
        if ($urandom_range(0, 1)) r.operand_a = -r.operand_a;
      end
      case ($urandom_range(0, 9))
        0: r.operand_b = -$urandom_range(1, 5);
        1: r.operand_b = $urandom;
        default: r.operand_b = $urandom_range(0, 70);
      endcase
    end else begin
      r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // request driver: drive at the falling edge, hold until accepted
  // ------------------------------------------------------------------
  task automatic send_request(in_t req);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= req;
    do @(posedge clk); while (!(req_valid && req_ready));
    pending_results.push_back(predict_result(req));
    op_count[req.op]++;
    // end of burst: drop valid for a random gap, then start a new burst
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_request());
  endtask

  // ------------------------------------------------------------------
  // receiver: stall pattern in phases of random length, some with no stalls;
  // a long hold requested by a test is picked up and counted here
  // ------------------------------------------------------------------
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        long_hold = hold_request;
        hold_request = 0;
      end
      if (long_hold > 0) begin
        long_hold--;
        res_ready <= 1'b0;
      end else begin
        if (rx_phase_left == 0) begin
          rx_phase_left = $urandom_range(20, 200);
          rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_stall_cap);
        end
        rx_phase_left--;
        res_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // ------------------------------------------------------------------
  out_t want;

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d dz=%0b ovf=%0b", $time,
                 res_data.value, res_data.div_by_zero, res_data.overflow);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.div_by_zero) dz_seen++;
        if (want.overflow) sat_seen++;
        if (res_data.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch expected %0d actual %0d", $time,
                   want.value, res_data.value);
        end
        if (res_data.div_by_zero !== want.div_by_zero) begin
          errors++;
          $display("%0t: div_by_zero mismatch expected %0b actual %0b", $time,
                   want.div_by_zero, res_data.div_by_zero);
        end
        if (res_data.overflow !== want.overflow) begin
          errors++;
          $display("%0t: overflow mismatch expected %0b actual %0b", $time,
                   want.overflow, res_data.overflow);
        end
      end
    end
  end

  // watchdog: pending work with no handshake for too long ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (req_valid || pending_results.size() != 0) begin
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_add_sub();
    send_request(make_request(OP_ADD, MAX32, 32'sd1));    // wraps to min
    send_request(make_request(OP_ADD, MIN32, -32'sd1));   // wraps to max
    send_request(make_request(OP_SUB, MIN32, 32'sd1));
    send_request(make_request(OP_SUB, 32'sd0, MIN32));    // negating min stays min
  endtask

  task automatic test_multiply();
    send_request(make_request(OP_MUL, MAX32, MAX32));
    send_request(make_request(OP_MUL, MIN32, -32'sd1));
    send_request(make_request(OP_MUL, -32'sd1, -32'sd1));
  endtask

  task automatic test_divide();
    send_request(make_request(OP_DIV, 32'sd7, -32'sd2));  // truncates toward zero
    send_request(make_request(OP_DIV, -32'sd7, 32'sd2));
    send_request(make_request(OP_DIV, MAX32, 32'sd0));    // zero divisor
    send_request(make_request(OP_DIV, MIN32, -32'sd1));   // wraps, no flag
    send_request(make_request(OP_DIV, MIN32, MAX32));
  endtask

  task automatic test_power();
    send_request(make_request(OP_POW, 32'sd0, 32'sd0));   // zero exponent, zero base
    send_request(make_request(OP_POW, 32'sd5, -32'sd3));  // negative exponent
    send_request(make_request(OP_POW, 32'sd0, 32'sd5));
    send_request(make_request(OP_POW, -32'sd1, MAX32));   // odd exponent, unit base
    send_request(make_request(OP_POW, -32'sd1, 32'sd2));
    send_request(make_request(OP_POW, 32'sd2, 32'sd62));
    send_request(make_request(OP_POW, 32'sd2, 32'sd63));  // just past the top
    send_request(make_request(OP_POW, -32'sd2, 32'sd63)); // exactly the bottom
    send_request(make_request(OP_POW, -32'sd2, 32'sd65)); // saturates low
    send_request(make_request(OP_POW, MIN32, 32'sd2));
    send_request(make_request(OP_POW, MIN32, MAX32));
  endtask

  task automatic test_unused_ops();
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      send_request(make_request(c[2:0], MAX32, MIN32));
  endtask

  task automatic test_random_bursts();
    gap_max = 10;
    rx_stall_cap = 60;
    send_random(900);
  endtask

  // no idling on either side
  task automatic test_random_streaming();
    gap_max = 0;
    rx_stall_cap = 0;
    send_random(400);
  endtask

  // output held off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    gap_max = 0;
    hold_request = LONG_HOLD;
    send_random(30);
  endtask

  task automatic test_random_stalls();
    gap_max = 20;
    rx_stall_cap = 95;
    send_random(470);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_sub();
    test_multiply();
    test_divide();
    test_power();
    test_unused_ops();
    test_random_bursts();
    test_random_streaming();
    test_backpressure();
    test_random_stalls();

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: add %0d sub %0d mul %0d div %0d pow %0d unused %0d",
             results_checked, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
             op_count[OP_DIV], op_count[OP_POW],
             op_count[OP_UNUSED_LO] + op_count[OP_UNUSED_LO + 3'd1] +
             op_count[OP_UNUSED_HI]);
    $display("zero divisors %0d, saturated powers %0d, mismatches %0d",
             dz_seen, sat_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
